FILE: sv/chm_pkg.sv
// Package with request and response types and status and opcode codes.
`default_nettype none
package chm_pkg;
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_COUNT  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] key;
        logic [15:0] handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic [8:0]  item_count;
    } t_rsp;
endpackage
`default_nettype wire

FILE: sv/chained_hash_map_unit.sv
// Top level: chained hash map with a fixed entry pool, walked by a small sequencer.
// A count is answered straight from the idle state. A lookup, insert or remove steps through
// S_HEAD, then S_RDENT and S_CMP for each chain entry reached, then S_DONE; a remove hit
// goes by way of S_REM and an insert that takes an entry by way of S_POP and S_INS.
// Throughput: one request at a time; o_ready returns the cycle after the response is taken.
// After reset a clearing pass over max(BUCKETS, POOL_ENTRIES) indices empties the bucket heads
// and fills the free stack; no request is taken meanwhile.
`default_nettype none
module chained_hash_map_unit #(
    parameter int BUCKETS      = 64,
    parameter int POOL_ENTRIES = 256,
    parameter int HANDLE_BITS  = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  chm_pkg::t_req i_req,
    output logic          o_valid,
    input  wire           i_ready,
    output chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int LW = PW + 1;
    localparam int INIT_LEN = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
    localparam int IW = $clog2(INIT_LEN + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HEAD  = 9'b000000100,
        S_RDENT = 9'b000001000,
        S_CMP   = 9'b000010000,
        S_POP   = 9'b000100000,
        S_INS   = 9'b001000000,
        S_REM   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    logic [IW-1:0] r_init_cnt;
    t_req         r_req;
    logic [BW-1:0] r_bucket;
    logic [LW-1:0] r_cur, r_prev, r_head;
    logic [LW:0]   r_steps;
    logic [PW:0]   r_free_top;
    logic [LW-1:0] r_total;
    logic          r_out_valid;
    t_rsp          r_rsp;

    // Memories.
    logic [LW-1:0] m_head  [BUCKETS];
    logic [30:0]   m_key   [POOL_ENTRIES];
    logic [HANDLE_BITS-1:0] m_hdl [POOL_ENTRIES];
    logic [LW-1:0] m_link  [POOL_ENTRIES];
    logic [PW-1:0] m_free  [POOL_ENTRIES];
    logic [30:0]   r_rd_key;
    logic [HANDLE_BITS-1:0] r_rd_hdl;
    logic [LW-1:0] r_rd_link;
    logic [LW-1:0] r_rd_head;
    logic [PW-1:0] r_rd_free;

    logic [BW-1:0] w_bucket;
    logic [HANDLE_BITS-1:0] w_hdl16;

    // Bucket is key modulo the bucket count, a mask for powers of two.
    always_comb begin
        if ((1 << BW) == BUCKETS || BUCKETS == 1)
            w_bucket = (BUCKETS == 1) ? '0 : BW'(i_req.key);
        else
            w_bucket = BW'(i_req.key % BUCKETS);
    end
    assign w_hdl16 = HANDLE_BITS'(i_req.handle);

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // Memory reads and writes; the head is read at the incoming bucket while idle.
    always_ff @(posedge i_clk) begin
        r_rd_key  <= m_key[r_cur[PW-1:0]];
        r_rd_hdl  <= m_hdl[r_cur[PW-1:0]];
        r_rd_link <= m_link[r_cur[PW-1:0]];
        r_rd_head <= m_head[(r_state == S_IDLE) ? w_bucket : r_bucket];
        r_rd_free <= m_free[PW'(r_free_top - 1'b1)];
        if (r_state == S_INIT) begin
            if (r_init_cnt < IW'(BUCKETS))
                m_head[BW'(r_init_cnt)] <= NIL;
            if (r_init_cnt < IW'(POOL_ENTRIES))
                m_free[PW'(r_init_cnt)] <= PW'(r_init_cnt);
        end
        if (r_state == S_INS) begin
            m_key[r_rd_free]  <= r_req.key;
            m_hdl[r_rd_free]  <= HANDLE_BITS'(r_req.handle);
            m_link[r_rd_free] <= r_head;
            m_head[r_bucket]  <= {1'b0, r_rd_free};
        end
        if (r_state == S_REM) begin
            if (r_prev != NIL)
                m_link[r_prev[PW-1:0]] <= r_rd_link;
            else
                m_head[r_bucket] <= r_rd_link;
            if (r_free_top < (PW+1)'(POOL_ENTRIES))
                m_free[PW'(r_free_top)] <= r_cur[PW-1:0];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_free_top  <= (PW+1)'(POOL_ENTRIES);
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_init_cnt <= r_init_cnt + 1'b1;
                    if (r_init_cnt == IW'(INIT_LEN - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req    <= '{opcode: i_req.opcode, key: i_req.key,
                                      handle: 16'(w_hdl16)};
                        r_bucket <= w_bucket;
                        r_prev   <= NIL;
                        r_steps  <= '0;
                        if (t_opcode'(i_req.opcode) == OP_COUNT) begin
                            r_rsp <= '{status: ST_OK, found_handle: '0,
                                       item_count: 9'(r_total)};
                            r_out_valid <= 1'b1;
                        end else
                            r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_state <= S_RDENT;
                    r_cur   <= r_rd_head;
                    r_head  <= r_rd_head;
                end
                S_RDENT: begin
                    if (r_cur >= NIL || r_steps >= (LW+1)'(POOL_ENTRIES)) begin
                        r_cur <= NIL;
                        case (t_opcode'(r_req.opcode))
                            OP_INSERT: begin
                                if (r_free_top == '0 || r_free_top > (PW+1)'(POOL_ENTRIES)) begin
                                    r_rsp <= '{status: ST_FULL, found_handle: '0,
                                               item_count: 9'(r_total)};
                                    r_state <= S_DONE;
                                end else
                                    r_state <= S_POP;
                            end
                            default: begin
                                r_rsp <= '{status: ST_NOT_FOUND, found_handle: '0,
                                           item_count: 9'(r_total)};
                                r_state <= S_DONE;
                            end
                        endcase
                    end else
                        r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_rd_key == r_req.key) begin
                        case (t_opcode'(r_req.opcode))
                            OP_LOOKUP: begin
                                r_rsp <= '{status: ST_OK, found_handle: 16'(r_rd_hdl),
                                           item_count: 9'(r_total)};
                                r_state <= S_DONE;
                            end
                            OP_INSERT: begin
                                r_rsp <= '{status: ST_DUPLICATE, found_handle: '0,
                                           item_count: 9'(r_total)};
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_REM;
                        endcase
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_rd_link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_RDENT;
                    end
                end
                S_POP: r_state <= S_INS;
                S_INS: begin
                    r_free_top <= r_free_top - 1'b1;
                    r_total    <= r_total + 1'b1;
                    r_rsp <= '{status: ST_OK, found_handle: '0,
                               item_count: 9'(r_total + 1'b1)};
                    r_state <= S_DONE;
                end
                S_REM: begin
                    if (r_free_top < (PW+1)'(POOL_ENTRIES))
                        r_free_top <= r_free_top + 1'b1;
                    r_total <= (r_total != '0) ? r_total - 1'b1 : r_total;
                    r_rsp <= '{status: ST_OK, found_handle: '0,
                               item_count: 9'((r_total != '0) ? r_total - 1'b1 : r_total)};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks.
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= (PW+1)'(POOL_ENTRIES)) else $error("free top out of range");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_free_top + r_total == LW'(POOL_ENTRIES)))
        else $error("pool accounting broken");
endmodule
`default_nettype wire
